@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SRT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("start tree check failed");

// consequent must hold in the cycle after the antecedent
`define SRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("start tree check failed");

`endif

@@ rtl/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// srt_pkg
// types, constants and helpers of the start tree reaction timer
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  // field widths
  localparam int TIME_W     = 16;
  localparam int STATE_W    = 4;
  localparam int LAMP_W     = 6;
  localparam int RUNS_W     = 4;
  localparam int TAP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // reaction history
  localparam int HIST_DEPTH = 12;
  localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W      = TIME_W + $clog2(HIST_DEPTH);

  // serial divider, two quotient bits per cycle
  localparam int DIV_STEPS  = (SUM_W + 1) / 2;
  localparam int DIV_W      = 2 * DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [TIME_W-1:0] TIME_MAX        = {TIME_W{1'b1}};
  localparam logic [TAP_W-1:0]  TAP_MAX         = {TAP_W{1'b1}};
  localparam logic [TIME_W-1:0] STAGE_DELAY_RST = TIME_W'(2000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_HOLD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_STEP  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_STEP = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS       = CFG_IDX_W'(4);

  // configuration reset values
  localparam logic [TIME_W-1:0] PRE_HOLD_RST   = TIME_W'(500);
  localparam logic [TIME_W-1:0] TAP_WINDOW_RST = TIME_W'(1500);
  localparam logic [TIME_W-1:0] FULL_STEP_RST  = TIME_W'(500);
  localparam logic [TIME_W-1:0] SHORT_STEP_RST = TIME_W'(100);
  localparam logic [TAP_W-1:0]  TAPS_RST       = TAP_W'(3);

  // lamp bits
  localparam logic [LAMP_W-1:0] LAMP_STAGE = LAMP_W'(6'h01);
  localparam logic [LAMP_W-1:0] LAMP_AMB1  = LAMP_W'(6'h02);
  localparam logic [LAMP_W-1:0] LAMP_AMB2  = LAMP_W'(6'h04);
  localparam logic [LAMP_W-1:0] LAMP_AMB3  = LAMP_W'(6'h08);
  localparam logic [LAMP_W-1:0] LAMP_GREEN = LAMP_W'(6'h10);
  localparam logic [LAMP_W-1:0] LAMP_RED   = LAMP_W'(6'h20);

  typedef enum logic [STATE_W-1:0] {
    PH_IDLE      = 4'd0,
    PH_PRE       = 4'd1,
    PH_STAGE     = 4'd2,
    PH_AMB1      = 4'd3,
    PH_AMB2      = 4'd4,
    PH_AMB3      = 4'd5,
    PH_GREEN     = 4'd6,
    PH_RED_END   = 4'd7,
    PH_GREEN_END = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_READ,
    CTL_DIV,
    CTL_LOAD
  } ctl_e;

  typedef struct packed {
    logic [TIME_W-1:0] pre_hold;
    logic [TIME_W-1:0] tap_window;
    logic [TIME_W-1:0] full_step;
    logic [TIME_W-1:0] short_step;
    logic [TAP_W-1:0]  taps;
  } cfg_t;

  // sequencer status towards the top level
  typedef struct packed {
    phase_e            phase;
    logic              short_mode;
    logic              rec;
    logic [TIME_W-1:0] rec_time;
    logic [TIME_W-1:0] red_total;
  } seq_status_t;

  // history status towards the top level
  typedef struct packed {
    logic [TIME_W-1:0] last;
    logic [TIME_W-1:0] best;
    logic [TIME_W-1:0] avg;
    logic [FILL_W-1:0] fill;
    logic              div_done;
  } hist_status_t;

  typedef struct packed {
    logic [STATE_W-1:0] tree_state;
    logic [LAMP_W-1:0]  lamps;
    logic               short_mode;
    logic               reaction_valid;
    logic [TIME_W-1:0]  last_reaction_ms;
    logic [TIME_W-1:0]  best_reaction_ms;
    logic [TIME_W-1:0]  average_reaction_ms;
    logic [RUNS_W-1:0]  runs_stored;
    logic [TIME_W-1:0]  red_light_total;
  } out_item_t;

  // lamp pattern shown in each phase
  function automatic logic [LAMP_W-1:0] lamp_code(phase_e ph);
    logic [LAMP_W-1:0] l;
    unique case (ph)
      PH_STAGE:     l = LAMP_STAGE;
      PH_AMB1:      l = LAMP_STAGE | LAMP_AMB1;
      PH_AMB2:      l = LAMP_STAGE | LAMP_AMB1 | LAMP_AMB2;
      PH_AMB3:      l = LAMP_STAGE | LAMP_AMB1 | LAMP_AMB2 | LAMP_AMB3;
      PH_GREEN:     l = LAMP_STAGE | LAMP_AMB1 | LAMP_AMB2 | LAMP_AMB3 | LAMP_GREEN;
      PH_RED_END:   l = LAMP_RED;
      PH_GREEN_END: l = LAMP_GREEN;
      default:      l = '0;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

@@ rtl/srt_if.sv @@
// ----------------------------------------------------------------------------
// srt_in_if / srt_out_if
// valid/ready channels for tick transactions and result transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface srt_in_if;
  import srt_pkg::*;

  logic              valid;
  logic              ready;
  logic              button_pressed;
  logic [TIME_W-1:0] stage_delay_draw;

  modport source (output valid, output button_pressed, output stage_delay_draw,
                  input ready);
  modport sink   (input valid, input button_pressed, input stage_delay_draw,
                  output ready);
endinterface

interface srt_out_if;
  import srt_pkg::*;

  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] tree_state;
  logic [LAMP_W-1:0]  lamps;
  logic               short_mode;
  logic               reaction_valid;
  logic [TIME_W-1:0]  last_reaction_ms;
  logic [TIME_W-1:0]  best_reaction_ms;
  logic [TIME_W-1:0]  average_reaction_ms;
  logic [RUNS_W-1:0]  runs_stored;
  logic [TIME_W-1:0]  red_light_total;

  modport source (output valid, output tree_state, output lamps, output short_mode,
                  output reaction_valid, output last_reaction_ms,
                  output best_reaction_ms, output average_reaction_ms,
                  output runs_stored, output red_light_total, input ready);
  modport sink   (input valid, input tree_state, input lamps, input short_mode,
                  input reaction_valid, input last_reaction_ms,
                  input best_reaction_ms, input average_reaction_ms,
                  input runs_stored, input red_light_total, output ready);
endinterface

`default_nettype wire

@@ rtl/start_tree_reaction_timer.sv @@
// ----------------------------------------------------------------------------
// start_tree_reaction_timer
// drag-race start tree with reaction timing and a twelve-run history
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick and gives exactly one result
// transaction. A tick that records no reaction goes from acceptance to the
// result register through accept, history ram read and load. A tick that
// records a reaction also writes the history ram and runs the serial average
// divider, which produces two quotient bits per cycle over a 20-bit sum,
// between the ram read and the load. The next tick is accepted once the result
// is in the output register, even while that result still waits to be taken.
// Configuration writes are taken at any time but are meant for idle periods.
`default_nettype none

module start_tree_reaction_timer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  srt_in_if.sink                             in_i,
  srt_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [srt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [srt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import srt_pkg::*;

  ctl_e         ctl_q, ctl_d;
  cfg_t         cfg_q;
  out_item_t    out_q;
  logic         out_valid_q, out_valid_d;
  logic         in_fire;
  logic         hist_upd;
  logic         out_load;
  seq_status_t  seq_st;
  hist_status_t hist_st;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_hold   <= PRE_HOLD_RST;
      cfg_q.tap_window <= TAP_WINDOW_RST;
      cfg_q.full_step  <= FULL_STEP_RST;
      cfg_q.short_step <= SHORT_STEP_RST;
      cfg_q.taps       <= TAPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRE_HOLD:   cfg_q.pre_hold   <= cfg_data_i;
        CFG_TAP_WINDOW: cfg_q.tap_window <= cfg_data_i;
        CFG_FULL_STEP:  cfg_q.full_step  <= cfg_data_i;
        CFG_SHORT_STEP: cfg_q.short_step <= cfg_data_i;
        CFG_TAPS:       cfg_q.taps       <= cfg_data_i[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_fire = in_i.valid && in_i.ready;

  srt_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_fire),
    .held_i   (in_i.button_pressed),
    .draw_i   (in_i.stage_delay_draw),
    .cfg_i    (cfg_q),
    .status_o (seq_st)
  );

  srt_hist u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_i     (in_fire),
    .upd_i    (hist_upd),
    .time_i   (seq_st.rec_time),
    .status_o (hist_st)
  );

  // transaction control next state
  always_comb begin
    ctl_d = ctl_q;
    unique case (ctl_q)
      CTL_IDLE: if (in_fire) ctl_d = CTL_READ;
      CTL_READ: ctl_d = seq_st.rec ? CTL_DIV : CTL_LOAD;
      CTL_DIV:  if (hist_st.div_done) ctl_d = CTL_LOAD;
      CTL_LOAD: if (!out_valid_q || out_o.ready) ctl_d = CTL_IDLE;
      default:  ctl_d = CTL_IDLE;
    endcase
  end

  // transaction control outputs
  always_comb begin
    in_i.ready = (ctl_q == CTL_IDLE);
    hist_upd   = (ctl_q == CTL_READ) && seq_st.rec;
    out_load   = (ctl_q == CTL_LOAD) && (!out_valid_q || out_o.ready);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CTL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.tree_state          <= seq_st.phase;
      out_q.lamps               <= lamp_code(seq_st.phase);
      out_q.short_mode          <= seq_st.short_mode;
      out_q.reaction_valid      <= seq_st.rec;
      out_q.last_reaction_ms    <= hist_st.last;
      out_q.best_reaction_ms    <= hist_st.best;
      out_q.average_reaction_ms <= hist_st.avg;
      out_q.runs_stored         <= RUNS_W'(hist_st.fill);
      out_q.red_light_total     <= seq_st.red_total;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.tree_state          = out_q.tree_state;
  assign out_o.lamps               = out_q.lamps;
  assign out_o.short_mode          = out_q.short_mode;
  assign out_o.reaction_valid      = out_q.reaction_valid;
  assign out_o.last_reaction_ms    = out_q.last_reaction_ms;
  assign out_o.best_reaction_ms    = out_q.best_reaction_ms;
  assign out_o.average_reaction_ms = out_q.average_reaction_ms;
  assign out_o.runs_stored         = out_q.runs_stored;
  assign out_o.red_light_total     = out_q.red_light_total;

endmodule

`default_nettype wire

@@ rtl/srt_ram.sv @@
// ----------------------------------------------------------------------------
// srt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/srt_div.sv @@
// ----------------------------------------------------------------------------
// srt_div
// restoring divider of the history sum by the fill count, two bits a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module srt_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [srt_pkg::SUM_W-1:0]  dividend_i,
  input  wire logic [srt_pkg::FILL_W-1:0] divisor_i,
  output logic                           done_o,
  output logic      [srt_pkg::TIME_W-1:0] quotient_o
);
  import srt_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [FILL_W:0]      rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [FILL_W-1:0]    dvs_q;
  logic [FILL_W:0]      shifted;
  logic                 last_step;

  assign last_step = busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  // two restoring steps; dividend bits leave the top of quo as quotient enters below
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    shifted = '0;
    for (int k = 0; k < 2; k++) begin
      shifted = {rem_d[FILL_W-1:0], quo_d[DIV_W-1]};
      quo_d   = {quo_d[DIV_W-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d    = shifted - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = shifted;
      end
    end
  end

  // control next values
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= DIV_W'(dividend_i);
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[TIME_W-1:0];

endmodule

`default_nettype wire

@@ rtl/srt_hist.sv @@
// ----------------------------------------------------------------------------
// srt_hist
// reaction history ring in ram with running sum, fill count, best and average
// ----------------------------------------------------------------------------
`default_nettype none

module srt_hist (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      rd_i,
  input  wire logic                      upd_i,
  input  wire logic [srt_pkg::TIME_W-1:0] time_i,
  output srt_pkg::hist_status_t          status_o
);
  import srt_pkg::*;

  logic [HIST_IDX_W-1:0] ptr_q, ptr_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [TIME_W-1:0]     best_q, best_d;
  logic [TIME_W-1:0]     last_q, last_d;
  logic [TIME_W-1:0]     avg_q;
  logic [TIME_W-1:0]     oldest;
  logic [TIME_W-1:0]     quotient;
  logic                  full;
  logic                  div_done;

  // ring storage, the entry under the pointer is the oldest once full
  srt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (upd_i),
    .waddr_i (ptr_q),
    .wdata_i (time_i),
    .re_i    (rd_i),
    .raddr_i (ptr_q),
    .rdata_o (oldest)
  );

  assign full = (fill_q == FILL_W'(HIST_DEPTH));

  // record a new time: drop the oldest when full, advance the pointer
  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    best_d = best_q;
    last_d = last_q;
    if (upd_i) begin
      ptr_d  = (ptr_q == HIST_IDX_W'(HIST_DEPTH - 1)) ? '0 : ptr_q + HIST_IDX_W'(1);
      fill_d = full ? fill_q : fill_q + FILL_W'(1);
      sum_d  = sum_q - (full ? SUM_W'(oldest) : '0) + SUM_W'(time_i);
      last_d = time_i;
      if ((best_q == '0) || (time_i < best_q)) begin
        best_d = time_i;
      end
    end
  end

  // floor average of the updated history
  srt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (upd_i),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      best_q <= '0;
      last_q <= '0;
      avg_q  <= '0;
    end else begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
      best_q <= best_d;
      last_q <= last_d;
      if (div_done) begin
        avg_q <= quotient;
      end
    end
  end

  assign status_o.last     = last_q;
  assign status_o.best     = best_q;
  assign status_o.avg      = avg_q;
  assign status_o.fill     = fill_q;
  assign status_o.div_done = div_done;

endmodule

`default_nettype wire

@@ rtl/srt_seq.sv @@
// ----------------------------------------------------------------------------
// srt_seq
// start light sequencer: phases, phase timer, tap counting and red count
// ----------------------------------------------------------------------------
`default_nettype none

module srt_seq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic                      held_i,
  input  wire logic [srt_pkg::TIME_W-1:0] draw_i,
  input  wire srt_pkg::cfg_t             cfg_i,
  output srt_pkg::seq_status_t           status_o
);
  import srt_pkg::*;

  phase_e            phase_q, phase_d;
  logic [TIME_W-1:0] timer_q, timer_d;
  logic [TIME_W-1:0] delay_q, delay_d;
  logic              short_q, short_d;
  logic [TAP_W-1:0]  tally_q, tally_d;
  logic [TIME_W-1:0] since_q, since_d;
  logic [TIME_W-1:0] red_q, red_d;
  logic              rec_q, rec_d;
  logic [TIME_W-1:0] rec_time_q, rec_time_d;

  logic [TIME_W-1:0] timer_inc;
  logic [TIME_W-1:0] since_inc;
  logic [TIME_W-1:0] limit;
  logic              hit;
  logic              tapped;
  logic              enter_end;

  assign timer_inc = (timer_q == TIME_MAX) ? timer_q : timer_q + TIME_W'(1);
  assign since_inc = (since_q == TIME_MAX) ? since_q : since_q + TIME_W'(1);

  // length of the current timed phase
  always_comb begin
    unique case (phase_q)
      PH_PRE:   limit = cfg_i.pre_hold;
      PH_STAGE: limit = delay_q;
      default:  limit = short_q ? cfg_i.short_step : cfg_i.full_step;
    endcase
  end

  assign hit    = (timer_inc >= limit);
  assign tapped = step_i && (phase_q == PH_PRE) && !held_i;

  // phase next state
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q)
        PH_IDLE:  if (held_i) phase_d = PH_PRE;
        PH_PRE: begin
          if (!held_i) phase_d = PH_IDLE;
          else if (hit) phase_d = PH_STAGE;
        end
        PH_STAGE: begin
          if (!held_i) phase_d = PH_IDLE;
          else if (hit) phase_d = PH_AMB1;
        end
        PH_AMB1: begin
          if (!held_i) phase_d = PH_RED_END;
          else if (hit) phase_d = PH_AMB2;
        end
        PH_AMB2: begin
          if (!held_i) phase_d = PH_RED_END;
          else if (hit) phase_d = PH_AMB3;
        end
        PH_AMB3: begin
          if (!held_i) phase_d = PH_RED_END;
          else if (hit) phase_d = PH_GREEN;
        end
        PH_GREEN: if (!held_i) phase_d = PH_GREEN_END;
        PH_RED_END, PH_GREEN_END: if (held_i) phase_d = PH_IDLE;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  assign enter_end = (phase_d != phase_q) &&
                     ((phase_d == PH_RED_END) || (phase_d == PH_GREEN_END));

  // timers, taps, mode and counters
  always_comb begin
    logic [TAP_W-1:0] tal;
    timer_d    = timer_q;
    delay_d    = delay_q;
    short_d    = short_q;
    tally_d    = tally_q;
    since_d    = since_q;
    red_d      = red_q;
    rec_d      = rec_q;
    rec_time_d = rec_time_q;
    tal        = tally_q;
    if (step_i) begin
      since_d = since_inc;
      rec_d   = 1'b0;
      unique case (phase_q)
        PH_IDLE: if (held_i) timer_d = '0;
        PH_PRE, PH_STAGE, PH_AMB1, PH_AMB2, PH_AMB3: begin
          if (held_i) begin
            timer_d = hit ? '0 : timer_inc;
            if ((phase_q == PH_PRE) && hit) delay_d = draw_i;
          end
        end
        PH_GREEN: begin
          timer_d = timer_inc;
          if (!held_i) begin
            rec_d      = 1'b1;
            rec_time_d = timer_inc;
          end
        end
        default: ;
      endcase
      // a release during pre-stage counts as a tap
      if (tapped) begin
        if (since_inc < cfg_i.tap_window) begin
          tal = (tally_q == TAP_MAX) ? TAP_MAX : tally_q + TAP_W'(1);
        end else begin
          tal = TAP_W'(1);
        end
        since_d = '0;
        if (tal >= cfg_i.taps) begin
          short_d = ~short_q;
          tal     = '0;
        end
        tally_d = tal;
      end
      if (enter_end) tally_d = '0;
      if (enter_end && (phase_d == PH_RED_END)) red_d = red_q + TIME_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      timer_q    <= '0;
      delay_q    <= STAGE_DELAY_RST;
      short_q    <= 1'b0;
      tally_q    <= '0;
      since_q    <= '0;
      red_q      <= '0;
      rec_q      <= 1'b0;
      rec_time_q <= '0;
    end else begin
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      delay_q    <= delay_d;
      short_q    <= short_d;
      tally_q    <= tally_d;
      since_q    <= since_d;
      red_q      <= red_d;
      rec_q      <= rec_d;
      rec_time_q <= rec_time_d;
    end
  end

  assign status_o.phase      = phase_q;
  assign status_o.short_mode = short_q;
  assign status_o.rec        = rec_q;
  assign status_o.rec_time   = rec_time_q;
  assign status_o.red_total  = red_q;

endmodule

`default_nettype wire

@@ rtl/srt_checker.sv @@
// ----------------------------------------------------------------------------
// srt_checker
// port level checks of the start tree reaction timer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srt_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [srt_pkg::STATE_W-1:0] out_tree_state,
  input wire logic [srt_pkg::LAMP_W-1:0]  out_lamps,
  input wire logic                       out_reaction_valid,
  input wire logic [srt_pkg::TIME_W-1:0]  out_best,
  input wire logic [srt_pkg::TIME_W-1:0]  out_average,
  input wire logic [srt_pkg::RUNS_W-1:0]  out_runs
);
  import srt_pkg::*;

  // a waiting result keeps its fields
  `SRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tree_state) && $stable(out_lamps) && $stable(out_average))

  // a tick is worked on alone: no second acceptance right after one
  `SRT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // lamps always follow the reported tree state
  `SRT_ASSERT(a_lamps, out_valid |-> (out_lamps == lamp_code(phase_e'(out_tree_state))))

  // a recorded reaction only comes with the green end state
  `SRT_ASSERT(a_reaction_end, (out_valid && out_reaction_valid) |-> (out_tree_state == PH_GREEN_END))

  // an empty history has no best and no average
  `SRT_ASSERT(a_empty_hist, (out_valid && (out_runs == '0)) |-> ((out_best == '0) && (out_average == '0)))

endmodule

bind start_tree_reaction_timer srt_checker u_srt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid           (in_i.valid),
  .in_ready           (in_i.ready),
  .out_valid          (out_o.valid),
  .out_ready          (out_o.ready),
  .out_tree_state     (out_o.tree_state),
  .out_lamps          (out_o.lamps),
  .out_reaction_valid (out_o.reaction_valid),
  .out_best           (out_o.best_reaction_ms),
  .out_average        (out_o.average_reaction_ms),
  .out_runs           (out_o.runs_stored)
);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the start tree reaction timer tick by tick against a behavioural
// predictor kept in the bench; random idling on both channels, directed runs,
// register extremes, random light sequences and back-to-back ticks
// ----------------------------------------------------------------------------

module tb;
  import srt_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  srt_in_if  tick_ch ();
  srt_out_if result_ch ();

  start_tree_reaction_timer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_ch),
    .out_o      (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // bench control
  bit          idling_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned ticks_sent = 0;
  int unsigned error_count = 0;
  out_item_t   expected_results [$];

  // register mirror
  logic [TIME_W-1:0] pre_hold_cfg   = PRE_HOLD_RST;
  logic [TIME_W-1:0] tap_window_cfg = TAP_WINDOW_RST;
  logic [TIME_W-1:0] full_step_cfg  = FULL_STEP_RST;
  logic [TIME_W-1:0] short_step_cfg = SHORT_STEP_RST;
  logic [TAP_W-1:0]  taps_cfg       = TAPS_RST;

  // predicted tree state
  phase_e            tree_phase    = PH_IDLE;
  logic [TIME_W-1:0] phase_count   = '0;
  logic [TIME_W-1:0] stage_delay_q = STAGE_DELAY_RST;
  logic              short_mode_q  = 1'b0;
  logic [TAP_W-1:0]  tap_tally_q   = '0;
  logic [TIME_W-1:0] since_tap_q   = '0;
  logic [TIME_W-1:0] reaction_log [HIST_DEPTH];
  logic [FILL_W-1:0] log_fill      = '0;
  logic [SUM_W-1:0]  log_sum       = '0;
  logic [TIME_W-1:0] best_ms       = '0;
  logic [TIME_W-1:0] last_ms       = '0;
  logic [TIME_W-1:0] red_count     = '0;

  function automatic logic [TIME_W-1:0] sat_up(input logic [TIME_W-1:0] v);
    return (v == TIME_MAX) ? TIME_MAX : v + 1'b1;
  endfunction

  // one millisecond tick of the tree, returns the result it should give
  function automatic out_item_t advance_tree(input bit held, input logic [TIME_W-1:0] draw);
    phase_e            nxt;
    logic [TIME_W-1:0] step;
    bit                tapped;
    bit                recorded;
    out_item_t         r;
    nxt      = tree_phase;
    step     = short_mode_q ? short_step_cfg : full_step_cfg;
    tapped   = 1'b0;
    recorded = 1'b0;
    since_tap_q = sat_up(since_tap_q);

    case (tree_phase)
      PH_IDLE: begin
        if (held) begin
          nxt = PH_PRE;
          phase_count = '0;
        end
      end
      PH_PRE: begin
        if (!held) begin
          nxt = PH_IDLE;
          tapped = 1'b1;
        end else begin
          phase_count = sat_up(phase_count);
          if (phase_count >= pre_hold_cfg) begin
            stage_delay_q = draw;
            phase_count = '0;
            nxt = PH_STAGE;
          end
        end
      end
      PH_STAGE: begin
        if (!held) begin
          nxt = PH_IDLE;
        end else begin
          phase_count = sat_up(phase_count);
          if (phase_count >= stage_delay_q) begin
            phase_count = '0;
            nxt = PH_AMB1;
          end
        end
      end
      PH_AMB1, PH_AMB2, PH_AMB3: begin
        if (!held) begin
          nxt = PH_RED_END;
        end else begin
          phase_count = sat_up(phase_count);
          if (phase_count >= step) begin
            phase_count = '0;
            nxt = phase_e'(tree_phase + 1'b1);
          end
        end
      end
      PH_GREEN: begin
        phase_count = sat_up(phase_count);
        if (!held) begin
          // log the reaction, dropping the oldest entry once full
          last_ms = phase_count;
          if (log_fill >= HIST_DEPTH) log_sum = log_sum - reaction_log[HIST_DEPTH-1];
          for (int i = HIST_DEPTH - 1; i > 0; i--) reaction_log[i] = reaction_log[i-1];
          reaction_log[0] = phase_count;
          log_sum = log_sum + phase_count;
          if (log_fill < HIST_DEPTH) log_fill = log_fill + 1'b1;
          if (best_ms == '0 || phase_count < best_ms) best_ms = phase_count;
          recorded = 1'b1;
          nxt = PH_GREEN_END;
        end
      end
      PH_RED_END, PH_GREEN_END: begin
        if (held) nxt = PH_IDLE;
      end
      default: begin
        nxt = PH_IDLE;
      end
    endcase

    // quick taps toggle the step mode
    if (tapped) begin
      if (since_tap_q < tap_window_cfg)
        tap_tally_q = (tap_tally_q == TAP_MAX) ? TAP_MAX : tap_tally_q + 1'b1;
      else
        tap_tally_q = TAP_W'(1);
      since_tap_q = '0;
      if (tap_tally_q >= taps_cfg) begin
        short_mode_q = ~short_mode_q;
        tap_tally_q = '0;
      end
    end
    if (nxt != tree_phase && (nxt == PH_RED_END || nxt == PH_GREEN_END)) tap_tally_q = '0;
    if (nxt != tree_phase && nxt == PH_RED_END) red_count = red_count + 1'b1;
    tree_phase = nxt;

    r.tree_state = tree_phase;
    case (tree_phase)
      PH_STAGE:     r.lamps = LAMP_STAGE;
      PH_AMB1:      r.lamps = LAMP_STAGE | LAMP_AMB1;
      PH_AMB2:      r.lamps = LAMP_STAGE | LAMP_AMB1 | LAMP_AMB2;
      PH_AMB3:      r.lamps = LAMP_STAGE | LAMP_AMB1 | LAMP_AMB2 | LAMP_AMB3;
      PH_GREEN:     r.lamps = LAMP_STAGE | LAMP_AMB1 | LAMP_AMB2 | LAMP_AMB3 | LAMP_GREEN;
      PH_RED_END:   r.lamps = LAMP_RED;
      PH_GREEN_END: r.lamps = LAMP_GREEN;
      default:      r.lamps = '0;
    endcase
    r.short_mode          = short_mode_q;
    r.reaction_valid      = recorded;
    r.last_reaction_ms    = last_ms;
    r.best_reaction_ms    = best_ms;
    r.average_reaction_ms = (log_fill != '0) ? TIME_W'(log_sum / log_fill) : '0;
    r.runs_stored         = RUNS_W'(log_fill);
    r.red_light_total     = red_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result transaction: expected none, actual state %0d",
                 $time, result_ch.tree_state);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("tree_state", want.tree_state, result_ch.tree_state);
        check_field("lamps", want.lamps, result_ch.lamps);
        check_field("short_mode", want.short_mode, result_ch.short_mode);
        check_field("reaction_valid", want.reaction_valid, result_ch.reaction_valid);
        check_field("last_reaction_ms", want.last_reaction_ms, result_ch.last_reaction_ms);
        check_field("best_reaction_ms", want.best_reaction_ms, result_ch.best_reaction_ms);
        check_field("average_reaction_ms", want.average_reaction_ms,
                    result_ch.average_reaction_ms);
        check_field("runs_stored", want.runs_stored, result_ch.runs_stored);
        check_field("red_light_total", want.red_light_total, result_ch.red_light_total);
      end
    end
  end

  // result side, random stalls between transactions
  initial begin : result_sink
    int unsigned stall;
    result_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = stalls_on ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
    end
  end

  // one tick transaction, with a random gap in front of it
  task automatic send_tick(input bit held, input logic [TIME_W-1:0] draw);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid            <= 1'b1;
    tick_ch.button_pressed   <= held;
    tick_ch.stage_delay_draw <= draw;
    do @(posedge clk_i); while (!tick_ch.ready);
    expected_results.push_back(advance_tree(held, draw));
    ticks_sent++;
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic poke_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // reprogram every register once the tree has gone quiet
  task automatic write_setup(input logic [TIME_W-1:0] pre, input logic [TIME_W-1:0] win,
                             input logic [TIME_W-1:0] full, input logic [TIME_W-1:0] short_len,
                             input logic [TAP_W-1:0] taps);
    wait_drained();
    poke_reg(CFG_PRE_HOLD, pre);
    poke_reg(CFG_TAP_WINDOW, win);
    poke_reg(CFG_FULL_STEP, full);
    poke_reg(CFG_SHORT_STEP, short_len);
    poke_reg(CFG_TAPS, CFG_DATA_W'(taps));
    cfg_we_i <= 1'b0;
    pre_hold_cfg   = pre;
    tap_window_cfg = win;
    full_step_cfg  = full;
    short_step_cfg = short_len;
    taps_cfg       = taps;
  endtask

  // hold the button until the tree shows the wanted phase
  task automatic hold_until(input phase_e target);
    while (tree_phase != target) begin
      // a long staging delay or a held green would never get there
      if ((tree_phase == PH_STAGE && stage_delay_q > 16) || tree_phase == PH_GREEN)
        send_tick(1'b0, TIME_W'($urandom));
      else
        send_tick(1'b1, TIME_W'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_directed();
    write_setup(TIME_W'(1), TIME_W'(5), TIME_W'(1), TIME_W'(1), TAP_W'(3));
    // clean run with no staging delay, fastest reaction, then restart
    send_tick(1'b1, TIME_W'(0));
    send_tick(1'b1, TIME_W'(0));
    repeat (4) send_tick(1'b1, TIME_MAX);
    send_tick(1'b0, TIME_W'(0));
    send_tick(1'b1, TIME_W'(0));
    // release during the ambers gives red, press restarts
    send_tick(1'b1, TIME_W'(0));
    send_tick(1'b1, TIME_W'(1));
    send_tick(1'b1, TIME_W'(0));
    send_tick(1'b0, TIME_W'(0));
    send_tick(1'b1, TIME_W'(0));
    // three quick taps toggle the step mode
    repeat (3) begin
      send_tick(1'b1, TIME_W'(0));
      send_tick(1'b0, TIME_W'(0));
    end
    // release while staging on the longest delay
    send_tick(1'b1, TIME_W'(0));
    send_tick(1'b1, TIME_MAX);
    send_tick(1'b1, TIME_W'(0));
    send_tick(1'b0, TIME_W'(0));
  endtask

  task automatic test_register_extremes();
    write_setup(TIME_MAX, TIME_W'(1), TIME_MAX, TIME_MAX, TAP_MAX);
    // longest pre-stage hold cut short, tap outside the narrowest window
    repeat (4) send_tick(1'b1, TIME_W'($urandom));
    send_tick(1'b0, TIME_W'($urandom));
    write_setup(TIME_W'(1), TIME_MAX, TIME_MAX, TIME_MAX, TAP_W'(1));
    // longest amber step, released early
    hold_until(PH_AMB1);
    repeat (3) send_tick(1'b1, TIME_W'(0));
    send_tick(1'b0, TIME_W'(0));
    // a single tap toggles the mode
    send_tick(1'b1, TIME_W'(0));
    send_tick(1'b1, TIME_W'(0));
    send_tick(1'b0, TIME_W'(0));
    // longest step in the other mode, released early
    hold_until(PH_AMB1);
    send_tick(1'b1, TIME_W'(0));
    send_tick(1'b0, TIME_W'(0));
  endtask

  task automatic test_random();
    int unsigned kind;
    int unsigned round_start;
    phase_e      target;
    for (int round = 0; round < 4; round++) begin
      write_setup(TIME_W'($urandom_range(1, 3)),
                  (round == 3) ? TIME_MAX : TIME_W'($urandom_range(1, 12)),
                  TIME_W'($urandom_range(1, 4)), TIME_W'($urandom_range(1, 2)),
                  TAP_W'($urandom_range(1, 7)));
      round_start = ticks_sent;
      while (ticks_sent - round_start < 100) begin
        idling_on = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          // full run to green and a reaction
          hold_until(PH_GREEN);
          repeat ($urandom_range(0, 4)) send_tick(1'b1, TIME_W'($urandom));
          send_tick(1'b0, TIME_W'($urandom));
          repeat ($urandom_range(0, 2)) send_tick(1'b0, TIME_W'($urandom));
        end else if (kind < 70) begin
          // early release in a random phase
          target = phase_e'($urandom_range(PH_PRE, PH_AMB3));
          hold_until(target);
          send_tick(1'b0, TIME_W'($urandom));
        end else if (kind < 85) begin
          // burst of pre-stage taps
          hold_until(PH_PRE);
          repeat ($urandom_range(1, 7)) begin
            send_tick(1'b0, TIME_W'($urandom));
            repeat ($urandom_range(0, 2)) send_tick(1'b0, TIME_W'($urandom));
            send_tick(1'b1, TIME_W'($urandom));
          end
        end else begin
          // noise on the button
          repeat ($urandom_range(1, 8))
            send_tick(1'($urandom_range(0, 1)), TIME_W'($urandom));
        end
        if ($urandom_range(0, 15) == 0) wait_drained();
      end
    end
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    stalls_on = 1'b0;
    write_setup(TIME_W'(1), TIME_MAX, TIME_W'(1), TIME_W'(1), TAP_W'(2));
    // green held for a while with no gaps on either channel, slow reaction
    hold_until(PH_GREEN);
    repeat (40) send_tick(1'b1, TIME_W'($urandom));
    send_tick(1'b0, TIME_W'($urandom));
    // two taps inside the widest window toggle the mode
    send_tick(1'b1, TIME_W'(0));
    repeat (2) begin
      send_tick(1'b1, TIME_W'(0));
      send_tick(1'b0, TIME_W'(0));
    end
    idling_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin : main_sequence
    rst_ni                   <= 1'b0;
    cfg_we_i                 <= 1'b0;
    cfg_idx_i                <= CFG_PRE_HOLD;
    cfg_data_i               <= '0;
    tick_ch.valid            <= 1'b0;
    tick_ch.button_pressed   <= 1'b0;
    tick_ch.stage_delay_draw <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_random();
    test_back_to_back();
    wait_drained();
    // let any stray result transaction show up
    repeat (32) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
